// File: hdl/parenthesized_infix_evaluator_assert.svh
// Assertion macros shared by the evaluator RTL.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef PARENTHESIZED_INFIX_EVALUATOR_ASSERT_SVH
`define PARENTHESIZED_INFIX_EVALUATOR_ASSERT_SVH

// Same-cycle implication, held off during reset
`define PIE_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, held off during reset
`define PIE_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/pie_pkg.sv
// Shared types and constants for the infix evaluator.
// No dependencies; imported by the top, front, queue and back modules.
`timescale 1ns / 1ps

package pie_pkg;

    // Character codes
    localparam logic [7:0] CH_ZERO  = 8'd48;
    localparam logic [7:0] CH_NINE  = 8'd57;
    localparam logic [7:0] CH_OPEN  = 8'd40;
    localparam logic [7:0] CH_CLOSE = 8'd41;
    localparam logic [7:0] CH_PLUS  = 8'd43;
    localparam logic [7:0] CH_MINUS = 8'd45;
    localparam logic [7:0] CH_STAR  = 8'd42;
    localparam logic [7:0] CH_SLASH = 8'd47;

    // Operator codes held on the operator stack
    localparam logic [1:0] OP_ADD = 2'd0;
    localparam logic [1:0] OP_SUB = 2'd1;
    localparam logic [1:0] OP_MUL = 2'd2;
    localparam logic [1:0] OP_DIV = 2'd3;

    // Result status codes
    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_INVALID = 3'd1;
    localparam logic [2:0] ST_DIVZERO = 3'd2;
    localparam logic [2:0] ST_UNDER   = 3'd3;
    localparam logic [2:0] ST_OVER    = 3'd4;

    // Command kinds passed from front to back
    localparam logic [2:0] K_NUM     = 3'd0;
    localparam logic [2:0] K_OP      = 3'd1;
    localparam logic [2:0] K_CLOSE   = 3'd2;
    localparam logic [2:0] K_END     = 3'd3;
    localparam logic [2:0] K_INVALID = 3'd4;

    // Command queue sizing
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [2:0] kind;
        logic [3:0] arg;    // digit value, or operator code in the low bits
    } t_cmd;

    typedef struct packed {
        logic [31:0] value;
        logic [2:0]  status;
        logic        last;
    } t_res;

endpackage

// File: hdl/parenthesized_infix_evaluator.sv
// Evaluator for fully parenthesised infix expressions with single-digit operands.
// Input stream: tdata carries one character (bits 7:0), tlast marks end of expression.
// Output stream: tdata is the 32-bit value, tuser the 3-bit status, tlast the final flag.
// A result is produced for a close parenthesis, an end of expression, or any error
// (invalid character, stack under- or overflow, divide by zero); other characters
// produce nothing. A close parenthesis reads the right operand and operator (S_RHS),
// then the left operand (S_LHS); for / it waits on the 32-step iterative divider
// (S_DIV), then writes back and emits (S_EMIT). An end of expression uses S_END_RD.
// Characters enter a four-deep command queue, so the input keeps being taken while
// the back end is busy dividing; s_axis_tready falls only when that queue is full.
// Results sit in a single output register: while the receiver stalls, the back end
// holds the next command and the queue fills behind it.
// Reset (i_rst_n low, synchronous) empties both stacks, the queue and the output.
// Depends on pie_pkg, pie_front, pie_fifo and pie_back.
`timescale 1ns / 1ps

module parenthesized_infix_evaluator #(
    parameter int NUM_DEPTH = 64,
    parameter int OP_DEPTH  = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] char_code
    input  logic        s_axis_tlast,   // end_of_expr
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [31:0] value
    output logic [2:0]  m_axis_tuser,   // [2:0] status
    output logic        m_axis_tlast    // is_final
);
    import pie_pkg::*;

    logic q_full;
    logic q_push;
    t_cmd q_in;
    logic q_pop;
    logic q_valid;
    t_cmd q_out;
    t_res res;

    pie_front u_front (
        .i_valid      (s_axis_tvalid),
        .o_ready      (s_axis_tready),
        .i_char       (s_axis_tdata),
        .i_end        (s_axis_tlast),
        .i_queue_full (q_full),
        .o_push       (q_push),
        .o_cmd        (q_in)
    );

    pie_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_cmd   (q_out)
    );

    pie_back #(.NUM_DEPTH(NUM_DEPTH), .OP_DEPTH(OP_DEPTH)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (q_valid),
        .i_cmd       (q_out),
        .o_cmd_pop   (q_pop),
        .o_res_valid (m_axis_tvalid),
        .i_res_ready (m_axis_tready),
        .o_res       (res)
    );

    assign m_axis_tdata = res.value;
    assign m_axis_tuser = res.status;
    assign m_axis_tlast = res.last;

endmodule

// File: hdl/pie_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps

module pie_ram #(
    parameter int W     = 32,
    parameter int DEPTH = 64,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [W-1:0]  i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [W-1:0]  o_rdata
);

    logic [W-1:0] r_mem [DEPTH];
    logic [W-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: hdl/pie_fifo.sv
// Short command queue between the front and back of the evaluator.
// Depends on pie_pkg for the command type and queue sizing.
`timescale 1ns / 1ps

module pie_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  pie_pkg::t_cmd i_cmd,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_valid,
    output pie_pkg::t_cmd o_cmd
);
    import pie_pkg::*;

    t_cmd                r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr;
    logic [QUEUE_AW-1:0] r_rd;
    logic [QUEUE_CW-1:0] r_cnt;

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + QUEUE_AW'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + QUEUE_AW'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + QUEUE_CW'(1);
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - QUEUE_CW'(1);
            end
        end
    end

    // Storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    assign o_full  = (r_cnt == QUEUE_CW'(QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_cmd   = r_mem[r_rd];

endmodule

// File: hdl/pie_front.sv
// Front end: accepts characters and classifies them into queue commands.
// Depends on pie_pkg; feeds pie_fifo.
`timescale 1ns / 1ps

module pie_front (
    input  logic          i_valid,
    output logic          o_ready,
    input  logic [7:0]    i_char,
    input  logic          i_end,
    input  logic          i_queue_full,
    output logic          o_push,
    output pie_pkg::t_cmd o_cmd
);
    import pie_pkg::*;

    logic w_keep;
    logic [7:0] w_digit;

    assign w_digit = i_char - CH_ZERO;

    // Classify one character; an open parenthesis is dropped here
    always_comb begin
        w_keep     = 1'b1;
        o_cmd.kind = K_INVALID;
        o_cmd.arg  = '0;
        if (i_end) begin
            o_cmd.kind = K_END;
        end else if (i_char == CH_OPEN) begin
            w_keep = 1'b0;
        end else if (i_char >= CH_ZERO && i_char <= CH_NINE) begin
            o_cmd.kind = K_NUM;
            o_cmd.arg  = w_digit[3:0];
        end else begin
            unique case (i_char)
                CH_PLUS: begin
                    o_cmd.kind = K_OP;
                    o_cmd.arg  = {2'b00, OP_ADD};
                end
                CH_MINUS: begin
                    o_cmd.kind = K_OP;
                    o_cmd.arg  = {2'b00, OP_SUB};
                end
                CH_STAR: begin
                    o_cmd.kind = K_OP;
                    o_cmd.arg  = {2'b00, OP_MUL};
                end
                CH_SLASH: begin
                    o_cmd.kind = K_OP;
                    o_cmd.arg  = {2'b00, OP_DIV};
                end
                CH_CLOSE: begin
                    o_cmd.kind = K_CLOSE;
                end
                default: begin
                    o_cmd.kind = K_INVALID;
                end
            endcase
        end
    end

    assign o_ready = !i_queue_full;
    assign o_push  = i_valid && !i_queue_full && w_keep;

endmodule

// File: hdl/pie_div.sv
// Iterative signed 32-bit divider, one quotient bit per cycle, truncating.
// No package dependency; used by pie_back.
`timescale 1ns / 1ps

module pie_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_num,
    input  logic [31:0] i_den,
    output logic        o_busy,
    output logic        o_done,
    output logic [31:0] o_quo
);

    logic        r_busy;
    logic        r_done;
    logic [4:0]  r_step;
    logic [31:0] r_rem;
    logic [31:0] r_quo;
    logic [31:0] r_den;
    logic        r_neg;
    logic [32:0] w_rem_sh;
    logic [33:0] w_diff;

    // One restoring step
    assign w_rem_sh = {r_rem, r_quo[31]};
    assign w_diff   = {1'b0, w_rem_sh} - {2'b00, r_den};

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + 5'd1;
                if (r_step == 5'd31) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: operands taken as magnitudes, sign applied at the output
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_num[31] ? (32'd0 - i_num) : i_num;
            r_den <= i_den[31] ? (32'd0 - i_den) : i_den;
            r_neg <= i_num[31] ^ i_den[31];
        end else if (r_busy) begin
            if (!w_diff[33]) begin
                r_rem <= w_diff[31:0];
                r_quo <= {r_quo[30:0], 1'b1};
            end else begin
                r_rem <= w_rem_sh[31:0];
                r_quo <= {r_quo[30:0], 1'b0};
            end
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_quo  = r_neg ? (32'd0 - r_quo) : r_quo;

endmodule

// File: hdl/pie_back.sv
// Back end: runs the number and operator stacks, the ALU and the result register.
// Depends on pie_pkg, pie_ram, pie_div and the assertion macro header.
`timescale 1ns / 1ps
`include "parenthesized_infix_evaluator_assert.svh"

module pie_back #(
    parameter int NUM_DEPTH = 64,
    parameter int OP_DEPTH  = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cmd_valid,
    input  pie_pkg::t_cmd i_cmd,
    output logic          o_cmd_pop,
    output logic          o_res_valid,
    input  logic          i_res_ready,
    output pie_pkg::t_res o_res
);
    import pie_pkg::*;

    localparam int NUM_AW = (NUM_DEPTH > 1) ? $clog2(NUM_DEPTH) : 1;
    localparam int NUM_CW = $clog2(NUM_DEPTH + 1);
    localparam int OP_AW  = (OP_DEPTH > 1) ? $clog2(OP_DEPTH) : 1;
    localparam int OP_CW  = $clog2(OP_DEPTH + 1);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_END_RD = 3'd1;
    localparam logic [2:0] S_RHS    = 3'd2;
    localparam logic [2:0] S_LHS    = 3'd3;
    localparam logic [2:0] S_DIV    = 3'd4;
    localparam logic [2:0] S_EMIT   = 3'd5;

    logic [2:0]        r_state, n_state;
    logic [NUM_CW-1:0] r_num_cnt, n_num_cnt;
    logic [OP_CW-1:0]  r_op_cnt, n_op_cnt;
    logic [31:0]       r_rhs, n_rhs;
    logic [1:0]        r_op, n_op;
    logic [31:0]       r_res, n_res;
    logic [2:0]        r_status, n_status;
    logic              r_out_valid, n_out_valid;
    t_res              r_out, n_out;

    logic              w_out_free;
    logic [NUM_CW-1:0] w_num_m1;
    logic [NUM_CW-1:0] w_num_m2;
    logic [OP_CW-1:0]  w_op_m1;
    logic              num_we;
    logic [NUM_AW-1:0] num_waddr;
    logic [31:0]       num_wdata;
    logic [NUM_AW-1:0] num_raddr;
    logic [31:0]       num_rdata;
    logic              op_we;
    logic [1:0]        op_rdata;
    logic              div_start;
    logic              div_busy;
    logic              div_done;
    logic [31:0]       div_quo;

    assign w_num_m1   = r_num_cnt - NUM_CW'(1);
    assign w_num_m2   = r_num_cnt - NUM_CW'(2);
    assign w_op_m1    = r_op_cnt - OP_CW'(1);
    assign w_out_free = !r_out_valid || i_res_ready;
    assign num_raddr  = (r_state == S_RHS) ? w_num_m2[NUM_AW-1:0] : w_num_m1[NUM_AW-1:0];

    // Stacks
    pie_ram #(.W(32), .DEPTH(NUM_DEPTH)) u_num_ram (
        .i_clk   (i_clk),
        .i_we    (num_we),
        .i_waddr (num_waddr),
        .i_wdata (num_wdata),
        .i_raddr (num_raddr),
        .o_rdata (num_rdata)
    );

    pie_ram #(.W(2), .DEPTH(OP_DEPTH)) u_op_ram (
        .i_clk   (i_clk),
        .i_we    (op_we),
        .i_waddr (r_op_cnt[OP_AW-1:0]),
        .i_wdata (i_cmd.arg[1:0]),
        .i_raddr (w_op_m1[OP_AW-1:0]),
        .o_rdata (op_rdata)
    );

    pie_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (num_rdata),
        .i_den   (r_rhs),
        .o_busy  (div_busy),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    // Sequencer
    always_comb begin
        n_state     = r_state;
        n_num_cnt   = r_num_cnt;
        n_op_cnt    = r_op_cnt;
        n_rhs       = r_rhs;
        n_op        = r_op;
        n_res       = r_res;
        n_status    = r_status;
        n_out_valid = r_out_valid && !i_res_ready;
        n_out       = r_out;
        o_cmd_pop   = 1'b0;
        num_we      = 1'b0;
        num_waddr   = r_num_cnt[NUM_AW-1:0];
        num_wdata   = {28'd0, i_cmd.arg};
        op_we       = 1'b0;
        div_start   = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_cmd_valid && w_out_free) begin
                    o_cmd_pop = 1'b1;
                    unique case (i_cmd.kind)
                        K_NUM: begin
                            if (r_num_cnt >= NUM_CW'(NUM_DEPTH)) begin
                                n_out_valid = 1'b1;
                                n_out       = '{value: '0, status: ST_OVER, last: 1'b0};
                            end else begin
                                num_we    = 1'b1;
                                n_num_cnt = r_num_cnt + NUM_CW'(1);
                            end
                        end
                        K_OP: begin
                            if (r_op_cnt >= OP_CW'(OP_DEPTH)) begin
                                n_out_valid = 1'b1;
                                n_out       = '{value: '0, status: ST_OVER, last: 1'b0};
                            end else begin
                                op_we    = 1'b1;
                                n_op_cnt = r_op_cnt + OP_CW'(1);
                            end
                        end
                        K_CLOSE: begin
                            if (r_num_cnt < NUM_CW'(2) || r_op_cnt == '0) begin
                                n_out_valid = 1'b1;
                                n_out       = '{value: '0, status: ST_UNDER, last: 1'b0};
                            end else begin
                                n_state = S_RHS;
                            end
                        end
                        K_END: begin
                            if (r_num_cnt == '0) begin
                                n_out_valid = 1'b1;
                                n_out       = '{value: '0, status: ST_UNDER, last: 1'b1};
                                n_op_cnt    = '0;
                            end else begin
                                n_state = S_END_RD;
                            end
                        end
                        default: begin
                            n_out_valid = 1'b1;
                            n_out       = '{value: '0, status: ST_INVALID, last: 1'b0};
                        end
                    endcase
                end
            end
            S_END_RD: begin
                n_out_valid = 1'b1;
                n_out       = '{value: num_rdata, status: ST_OK, last: 1'b1};
                n_num_cnt   = '0;
                n_op_cnt    = '0;
                n_state     = S_IDLE;
            end
            S_RHS: begin
                n_rhs   = num_rdata;
                n_op    = op_rdata;
                n_state = S_LHS;
            end
            S_LHS: begin
                n_status = ST_OK;
                n_state  = S_EMIT;
                unique case (r_op)
                    OP_ADD: n_res = num_rdata + r_rhs;
                    OP_SUB: n_res = num_rdata - r_rhs;
                    OP_MUL: n_res = num_rdata * r_rhs;
                    default: begin
                        if (r_rhs == '0) begin
                            n_res    = '0;
                            n_status = ST_DIVZERO;
                        end else begin
                            div_start = 1'b1;
                            n_state   = S_DIV;
                        end
                    end
                endcase
            end
            S_DIV: begin
                if (div_done) begin
                    n_res   = div_quo;
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                num_we      = 1'b1;
                num_waddr   = w_num_m2[NUM_AW-1:0];
                num_wdata   = r_res;
                n_num_cnt   = w_num_m1;
                n_op_cnt    = w_op_m1;
                n_out_valid = 1'b1;
                n_out       = '{value: r_res, status: r_status, last: 1'b0};
                n_state     = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_num_cnt   <= '0;
            r_op_cnt    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_num_cnt   <= n_num_cnt;
            r_op_cnt    <= n_op_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_rhs    <= n_rhs;
        r_op     <= n_op;
        r_res    <= n_res;
        r_status <= n_status;
        r_out    <= n_out;
    end

    assign o_res_valid = r_out_valid;
    assign o_res       = r_out;

    // Checks
    `PIE_ASSERT_IMP(a_err_zero, i_clk, i_rst_n, r_out_valid && r_out.status != ST_OK, r_out.value == '0, "error result carries a non-zero value")
    `PIE_ASSERT_IMP(a_pop_free, i_clk, i_rst_n, o_cmd_pop, w_out_free && r_state == S_IDLE, "command taken while result register busy")
    `PIE_ASSERT_IMP(a_div_owned, i_clk, i_rst_n, div_busy || div_done, r_state == S_DIV, "divider active outside divide state")
    `PIE_ASSERT_NXT(a_end_clear, i_clk, i_rst_n, r_state == S_END_RD, r_num_cnt == '0 && r_op_cnt == '0, "stacks not cleared after final answer")

endmodule
